// File: sv/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// Types and codes shared by the bytecode execute unit.
// ----------------------------------------------------------------------------
package bvm_pkg;

   localparam logic [4:0] OP_HALT   = 5'd0;
   localparam logic [4:0] OP_LDI    = 5'd1;
   localparam logic [4:0] OP_MOV    = 5'd2;
   localparam logic [4:0] OP_LDB    = 5'd3;
   localparam logic [4:0] OP_STB    = 5'd4;
   localparam logic [4:0] OP_XOR    = 5'd5;
   localparam logic [4:0] OP_AND    = 5'd6;
   localparam logic [4:0] OP_OR     = 5'd7;
   localparam logic [4:0] OP_ADD    = 5'd8;
   localparam logic [4:0] OP_SUB    = 5'd9;
   localparam logic [4:0] OP_NOT    = 5'd10;
   localparam logic [4:0] OP_SHL    = 5'd11;
   localparam logic [4:0] OP_SHR    = 5'd12;
   localparam logic [4:0] OP_PUSH   = 5'd13;
   localparam logic [4:0] OP_POP    = 5'd14;
   localparam logic [4:0] OP_JMP    = 5'd15;
   localparam logic [4:0] OP_JZ     = 5'd16;
   localparam logic [4:0] OP_JNZ    = 5'd17;
   localparam logic [4:0] OP_DECJNZ = 5'd18;
   localparam logic [4:0] OP_HWR    = 5'd19;
   localparam logic [4:0] OP_HRD    = 5'd20;
   localparam logic [4:0] OP_NOP    = 5'd31;

   localparam logic [12:0] DATA_SIZE_RESET = 13'd4096;
   localparam logic        REG_DATA_SIZE   = 1'b0;

   typedef struct packed {
      logic [4:0]  kind;
      logic [7:0]  reg_x;
      logic [7:0]  reg_y;
      logic [7:0]  reg_z;
      logic [31:0] immediate;
      logic [7:0]  shift_byte;
      logic [31:0] fall_through;
   } req_type;

   typedef struct packed {
      logic [31:0] next_location;
      logic        halted;
      logic        write_valid;
      logic [3:0]  written_reg;
      logic [31:0] written_value;
      logic [7:0]  read_byte;
   } rsp_type;

endpackage

// File: sv/bvm_ram.sv
// ----------------------------------------------------------------------------
// bvm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/bvm_front.sv
// ----------------------------------------------------------------------------
// bvm_front
// Accept words, reduce register indices modulo NUM_REGS and queue them for the back end.
// ----------------------------------------------------------------------------
module bvm_front #(
   parameter int NUM_REGS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bvm_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_pop,
   output bvm_pkg::req_type q_data
);
   bvm_pkg::req_type slot_ff [2];
   bvm_pkg::req_type norm;
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push;

   function automatic logic [7:0] midx(input logic [7:0] b);
      logic [15:0] r;
      r = {8'd0, b};
      if ((NUM_REGS & (NUM_REGS - 1)) == 0) begin
         r = r & 16'(NUM_REGS - 1);
      end else begin
         for (int s = 7; s >= 0; s--) begin
            if (r >= (16'(NUM_REGS) << s)) r = r - (16'(NUM_REGS) << s);
         end
      end
      return r[7:0];
   endfunction

   always_comb begin
      norm = req_data;
      norm.reg_x = midx(req_data.reg_x);
      norm.reg_y = midx(req_data.reg_y);
      norm.reg_z = midx(req_data.reg_z);
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = slot_ff[rp_ff];
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (q_pop) rp_ff <= ~rp_ff;
      end
      if (push) slot_ff[wp_ff] <= norm;
   end
endmodule

// File: sv/bvm_back.sv
// ----------------------------------------------------------------------------
// bvm_back
// Execute queued words: register file, data memory, stack and halt flag.
// ----------------------------------------------------------------------------
module bvm_back #(
   parameter int NUM_REGS    = 16,
   parameter int DATA_DEPTH  = 4096,
   parameter int STACK_DEPTH = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [12:0]      data_size,
   input  logic             q_valid,
   output logic             q_pop,
   input  bvm_pkg::req_type q_data,
   output logic             clearing,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bvm_pkg::rsp_type rsp_data
);
   localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int DW = $clog2(DATA_DEPTH);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int CW = SW + 1;

   // After S_CLEAR, a two-step sequencer: S_ISSUE reads operands, S_EXEC finishes.
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0] st_ff, st_in;
   logic [DW:0] clr_ff;
   logic [31:0] regs_ff [NUM_REGS];
   logic [CW-1:0] sp_ff;
   logic halt_ff;
   bvm_pkg::req_type cur_ff;
   logic [DW-1:0] laddr_ff;
   logic        lok_ff;
   bvm_pkg::rsp_type out_ff;
   logic out_v_ff;

   logic [31:0] vx, vy, vz, vy_c, vz_c, addr_s;
   logic [32:0] lim;
   logic        in_rng;
   logic        d_we, s_we;
   logic [DW-1:0] d_wa, d_ra;
   logic [7:0]  d_wd, d_rd;
   logic [SW-1:0] s_ra;
   logic [31:0] s_rd;
   logic [4:0]  k;
   logic        done;
   bvm_pkg::rsp_type res;
   logic [31:0] stb_addr;
   logic        stb_ok;

   assign clearing = (st_ff == S_CLEAR);
   assign lim = (33'(data_size) > 33'(DATA_DEPTH)) ? 33'(DATA_DEPTH) : 33'(data_size);

   assign vy_c = regs_ff[q_data.reg_y[RW-1:0]];
   assign vz_c = regs_ff[q_data.reg_z[RW-1:0]];
   assign vx = regs_ff[cur_ff.reg_x[RW-1:0]];
   assign vy = regs_ff[cur_ff.reg_y[RW-1:0]];
   assign vz = regs_ff[cur_ff.reg_z[RW-1:0]];

   // Load address in issue: host read uses immediate, ldb uses vy+vz.
   assign addr_s = (q_data.kind == bvm_pkg::OP_HRD) ? q_data.immediate : vy_c + vz_c;
   assign in_rng = {1'b0, addr_s} < lim;
   // Hold the read address while the result waits.
   assign d_ra   = q_pop ? addr_s[DW-1:0] : laddr_ff;
   assign s_ra   = SW'(sp_ff - CW'(1));

   assign stb_addr = vx + vy;
   assign stb_ok   = {1'b0, stb_addr} < lim;

   assign done  = (st_ff == S_EXEC) && (!out_v_ff || rsp_ready);
   assign q_pop = (st_ff == S_ISSUE) && q_valid;

   always_comb begin
      k = cur_ff.kind;
      if (halt_ff && k <= bvm_pkg::OP_DECJNZ) k = bvm_pkg::OP_NOP;
      res = '0;
      res.next_location = cur_ff.fall_through;
      d_we = 1'b0;
      d_wa = '0;
      d_wd = '0;
      s_we = 1'b0;
      if (st_ff == S_CLEAR) begin
         d_we = 1'b1;
         d_wa = clr_ff[DW-1:0];
      end
      unique case (k)
         bvm_pkg::OP_HALT: ;
         bvm_pkg::OP_LDI: begin
            res.write_valid = 1'b1; res.written_value = cur_ff.immediate;
         end
         bvm_pkg::OP_MOV: begin res.write_valid = 1'b1; res.written_value = vy; end
         bvm_pkg::OP_LDB: begin
            res.write_valid = 1'b1;
            res.written_value = lok_ff ? {24'd0, d_rd} : 32'd0;
         end
         bvm_pkg::OP_STB: begin
            if (done && stb_ok) begin
               d_we = 1'b1; d_wa = stb_addr[DW-1:0]; d_wd = vz[7:0];
            end
         end
         bvm_pkg::OP_XOR: begin res.write_valid = 1'b1; res.written_value = vy ^ vz; end
         bvm_pkg::OP_AND: begin res.write_valid = 1'b1; res.written_value = vy & vz; end
         bvm_pkg::OP_OR:  begin res.write_valid = 1'b1; res.written_value = vy | vz; end
         bvm_pkg::OP_ADD: begin res.write_valid = 1'b1; res.written_value = vy + vz; end
         bvm_pkg::OP_SUB: begin res.write_valid = 1'b1; res.written_value = vy - vz; end
         bvm_pkg::OP_NOT: begin res.write_valid = 1'b1; res.written_value = ~vy; end
         bvm_pkg::OP_SHL: begin
            res.write_valid = 1'b1; res.written_value = vy << cur_ff.shift_byte[4:0];
         end
         bvm_pkg::OP_SHR: begin
            res.write_valid = 1'b1; res.written_value = vy >> cur_ff.shift_byte[4:0];
         end
         bvm_pkg::OP_PUSH: s_we = done && (sp_ff < CW'(STACK_DEPTH));
         bvm_pkg::OP_POP: begin
            if (sp_ff != '0) begin
               res.write_valid = 1'b1; res.written_value = s_rd;
            end
         end
         bvm_pkg::OP_JMP: res.next_location = cur_ff.immediate;
         bvm_pkg::OP_JZ:  if (vx == 32'd0) res.next_location = cur_ff.immediate;
         bvm_pkg::OP_JNZ: if (vx != 32'd0) res.next_location = cur_ff.immediate;
         bvm_pkg::OP_DECJNZ: begin
            res.write_valid = 1'b1; res.written_value = vx - 32'd1;
            if (vx != 32'd1) res.next_location = cur_ff.immediate;
         end
         bvm_pkg::OP_HWR: begin
            if (done && ({1'b0, cur_ff.immediate} < lim)) begin
               d_we = 1'b1; d_wa = cur_ff.immediate[DW-1:0]; d_wd = cur_ff.shift_byte;
            end
         end
         bvm_pkg::OP_HRD: res.read_byte = lok_ff ? d_rd : 8'd0;
         default: ;
      endcase
      if (res.write_valid) res.written_reg = 4'(cur_ff.reg_x[RW-1:0]);
      res.halted = halt_ff || (k == bvm_pkg::OP_HALT);
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_CLEAR: if (clr_ff == (DW+1)'(DATA_DEPTH - 1)) st_in = S_ISSUE;
         S_ISSUE: if (q_valid) st_in = S_EXEC;
         S_EXEC:  if (done) st_in = S_ISSUE;
         default: st_in = S_ISSUE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_CLEAR;
         clr_ff   <= '0;
         sp_ff    <= '0;
         halt_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == S_CLEAR) clr_ff <= clr_ff + (DW+1)'(1);
         if (rsp_ready) out_v_ff <= 1'b0;
         if (done) begin
            out_v_ff <= 1'b1;
            if (res.write_valid) regs_ff[cur_ff.reg_x[RW-1:0]] <= res.written_value;
            if (k == bvm_pkg::OP_HALT) halt_ff <= 1'b1;
            if (s_we) sp_ff <= sp_ff + CW'(1);
            if (k == bvm_pkg::OP_POP && sp_ff != '0) sp_ff <= sp_ff - CW'(1);
         end
      end
      if (q_pop) begin
         cur_ff   <= q_data;
         laddr_ff <= addr_s[DW-1:0];
         lok_ff   <= in_rng;
      end
      if (done) out_ff <= res;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   bvm_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data (
      .clock(clock), .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra), .rd_data(d_rd)
   );

   bvm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(s_we), .wr_addr(sp_ff[SW-1:0]), .wr_data(vx),
      .rd_addr(s_ra), .rd_data(s_rd)
   );
endmodule

// File: sv/bytecode_vm_execute_unit_top.sv
// ----------------------------------------------------------------------------
// bytecode_vm_execute_unit_top
// The result word is registered after the word passes the front queue, the
// S_ISSUE operand read and the S_EXEC step; S_EXEC waits while an earlier
// result is not taken, and no new word is issued until it finishes.
// After reset all DATA_DEPTH bytes of the data memory are cleared while no word
// is accepted; registers, stack count and halt flag clear at once.
// ----------------------------------------------------------------------------
module bytecode_vm_execute_unit_top #(
   parameter int NUM_REGS    = 16,
   parameter int DATA_DEPTH  = 4096,
   parameter int STACK_DEPTH = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bvm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bvm_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [1:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [12:0] size_ff;
   logic f_ready, q_valid, q_pop, clearing;
   bvm_pkg::req_type q_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:0] == 2'd0) ? {19'd0, size_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= bvm_pkg::DATA_SIZE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         size_ff <= csr_pwdata[12:0];
      end
   end

   assign req_ready = f_ready && !clearing;

   bvm_front #(.NUM_REGS(NUM_REGS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid && !clearing),
      .req_ready(f_ready), .req_data(req_data), .q_valid(q_valid),
      .q_pop(q_pop), .q_data(q_data)
   );

   bvm_back #(.NUM_REGS(NUM_REGS), .DATA_DEPTH(DATA_DEPTH),
              .STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock(clock), .reset(reset), .data_size(size_ff), .q_valid(q_valid),
      .q_pop(q_pop), .q_data(q_data), .clearing(clearing),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule
